// ----- hdl/rrq_pkg.sv -----
// rrq_pkg: shared types, sizes and codes for the random removal queue.
// No dependencies; used by rrq_ctrl, rrq_datapath and random_removal_queue.
`timescale 1ns / 1ps

package rrq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int RAND_WIDTH = 16;

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int TRY_W  = IDX_W + 1;
  localparam int STEP_W = $clog2(RAND_WIDTH);

  localparam logic [1:0] KIND_ENQUEUE = 2'd0;
  localparam logic [1:0] KIND_OLDEST  = 2'd1;
  localparam logic [1:0] KIND_RANDOM  = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]            kind;
    logic [DATA_WIDTH-1:0] data_in;
    logic [RAND_WIDTH-1:0] random_value;
  } req_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] data_out;
    logic [1:0]            status;
    logic [CNT_W-1:0]      entries_held;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic needs_div;
    logic div_done;
  } dp_status_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EXEC = 3'b100
  } state_t;

endpackage

// ----- hdl/rrq_ctrl.sv -----
// rrq_ctrl: sequencing state machine and response valid for the queue.
// Depends on rrq_pkg; drives the command struct of rrq_datapath.
`timescale 1ns / 1ps

module rrq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  input  rrq_pkg::dp_status_t dp_status,
  output rrq_pkg::cmd_t      cmd
);

  rrq_pkg::state_t state;
  rrq_pkg::state_t state_next;
  logic            rsp_free;

  assign req_stall = (state != rrq_pkg::ST_IDLE);
  assign rsp_free  = !rsp_valid || !rsp_stall;

  always_comb begin
    state_next   = state;
    cmd.load     = 1'b0;
    cmd.div_step = 1'b0;
    cmd.exec     = 1'b0;
    case (state)
      rrq_pkg::ST_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = dp_status.needs_div ? rrq_pkg::ST_DIV : rrq_pkg::ST_EXEC;
        end
      end
      rrq_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (dp_status.div_done) begin
          state_next = rrq_pkg::ST_EXEC;
        end
      end
      rrq_pkg::ST_EXEC: begin
        if (rsp_free) begin
          cmd.exec   = 1'b1;
          state_next = rrq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rrq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rrq_pkg::ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.exec) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/rrq_datapath.sv -----
// rrq_datapath: entry storage with gap-closing shift, bit-serial modulo
// unit and response register. Depends on rrq_pkg; commanded by rrq_ctrl.
`timescale 1ns / 1ps

module rrq_datapath (
  input  logic                clk,
  input  logic                rst,
  input  rrq_pkg::req_t       req,
  input  rrq_pkg::cmd_t       cmd,
  output rrq_pkg::dp_status_t dp_status,
  output rrq_pkg::rsp_t       rsp
);

  logic [rrq_pkg::DATA_WIDTH-1:0] slots [rrq_pkg::DEPTH];
  logic [rrq_pkg::CNT_W-1:0]      count;

  logic [1:0]                     kind;
  logic [rrq_pkg::DATA_WIDTH-1:0] word;
  logic [rrq_pkg::RAND_WIDTH-1:0] rnd_sh;
  logic [rrq_pkg::IDX_W-1:0]      rem;
  logic [rrq_pkg::STEP_W-1:0]     step;

  logic [rrq_pkg::TRY_W-1:0]      trial;
  logic                           fits;
  logic [rrq_pkg::CNT_W-1:0]      pos_wide;
  logic [rrq_pkg::IDX_W-1:0]      pos;
  logic                           is_remove;
  logic                           is_empty;
  logic                           is_full;
  logic                           do_take;
  logic                           do_put;

  // restoring remainder, one dividend bit per cycle
  assign trial = {rem, rnd_sh[rrq_pkg::RAND_WIDTH-1]};
  assign fits  = (trial >= rrq_pkg::TRY_W'(count));

  assign dp_status.needs_div = (req.kind == rrq_pkg::KIND_RANDOM) && (count != '0);
  assign dp_status.div_done  = (step == rrq_pkg::STEP_W'(rrq_pkg::RAND_WIDTH - 1));

  // remainder counts from the newest entry
  assign pos_wide  = count - rrq_pkg::CNT_W'(1) - rrq_pkg::CNT_W'(rem);
  assign pos       = (kind == rrq_pkg::KIND_OLDEST) ? '0 : pos_wide[rrq_pkg::IDX_W-1:0];
  assign is_remove = (kind == rrq_pkg::KIND_OLDEST) || (kind == rrq_pkg::KIND_RANDOM);
  assign is_empty  = (count == '0);
  assign is_full   = (count >= rrq_pkg::CNT_W'(rrq_pkg::DEPTH));
  assign do_take   = cmd.exec && is_remove && !is_empty;
  assign do_put    = cmd.exec && (kind == rrq_pkg::KIND_ENQUEUE) && !is_full;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind   <= req.kind;
      word   <= req.data_in;
      rnd_sh <= req.random_value;
      rem    <= '0;
      step   <= '0;
    end else if (cmd.div_step) begin
      rnd_sh <= {rnd_sh[rrq_pkg::RAND_WIDTH-2:0], 1'b0};
      rem    <= fits ? rrq_pkg::IDX_W'(trial - rrq_pkg::TRY_W'(count))
                     : rrq_pkg::IDX_W'(trial);
      step   <= step + rrq_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_put) begin
      slots[count[rrq_pkg::IDX_W-1:0]] <= word;
    end
    if (do_take) begin
      for (int i = 0; i < rrq_pkg::DEPTH - 1; i++) begin
        if (rrq_pkg::IDX_W'(i) >= pos) begin
          slots[i] <= slots[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (do_put) begin
      count <= count + rrq_pkg::CNT_W'(1);
    end else if (do_take) begin
      count <= count - rrq_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rsp.data_out <= do_take ? slots[pos] : '0;
      if (is_remove && is_empty) begin
        rsp.status <= rrq_pkg::STATUS_EMPTY;
      end else if ((kind == rrq_pkg::KIND_ENQUEUE) && is_full) begin
        rsp.status <= rrq_pkg::STATUS_FULL;
      end else begin
        rsp.status <= rrq_pkg::STATUS_OK;
      end
      if (do_put) begin
        rsp.entries_held <= count + rrq_pkg::CNT_W'(1);
      end else if (do_take) begin
        rsp.entries_held <= count - rrq_pkg::CNT_W'(1);
      end else begin
        rsp.entries_held <= count;
      end
    end
  end

endmodule

// ----- hdl/random_removal_queue.sv -----
// random_removal_queue: top level joining rrq_ctrl and rrq_datapath.
// Depends on rrq_pkg, rrq_ctrl and rrq_datapath.
//
// Bounded queue of DEPTH words. A request carries kind, data_in and
// random_value; kind selects enqueue as newest, remove oldest, or remove
// the entry at (random_value mod count) counted from the newest. Every
// request gives one response with data_out, status and entries_held.
// Both channels use valid/stall; a request is taken when req_valid is
// high and req_stall low, a response when rsp_valid is high and
// rsp_stall low.
// Timing: the request is taken in idle and executed in the execute state;
// the response register and rsp_valid are loaded at the execute step, and
// the controller returns to idle at the same edge, so the next request can
// be taken while that response is valid. A random removal from a non-empty
// queue first runs the bit-serial modulo unit, one step per bit of
// random_value, before its execute step.
// One request is in work at a time; req_stall is low only in idle.
// A finished response waits in the output register while the next
// request is taken; that request's execute step holds until the
// waiting response is taken.
// Reset empties the queue and drops any response not yet taken.
`timescale 1ns / 1ps

module random_removal_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  rrq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output rrq_pkg::rsp_t rsp
);

  rrq_pkg::cmd_t       cmd;
  rrq_pkg::dp_status_t dp_status;

  rrq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .dp_status (dp_status),
    .cmd       (cmd)
  );

  rrq_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .dp_status (dp_status),
    .rsp       (rsp)
  );

endmodule
